FILE: rtl/gre_tm_pkg.sv
// ----------------------------------------------------------------------------
// gre_tm_pkg
// Shared types and constants for the GRE tunnel match and header parse block.
// ----------------------------------------------------------------------------
package gre_tm_pkg;

    localparam int IDX_W   = 4;
    localparam int SLOTS   = 2 ** IDX_W;
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int HLEN_W  = 6;
    localparam int OFF_W   = 7;
    localparam int WORD_W  = 16;
    localparam int VERD_W  = 2;

    localparam logic [PROTO_W-1:0] PROTO_GRE    = 8'd47;
    localparam logic [OFF_W-1:0]   GRE_BASE_LEN = 7'd4;
    localparam logic [OFF_W-1:0]   GRE_OPT_LEN  = 7'd4;

    localparam int BIT_CSUM  = 15;
    localparam int BIT_ROUTE = 14;
    localparam int BIT_KEY   = 13;
    localparam int BIT_SEQ   = 12;

    localparam logic [WORD_W-1:0] TYPE_IPV4  = 16'h0800;
    localparam logic [WORD_W-1:0] TYPE_WCCP  = 16'h883E;
    localparam logic [WORD_W-1:0] TYPE_ATALK = 16'h809B;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic [VERD_W-1:0] VERDICT_RAW   = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_IP    = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_ATALK = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] hit;
    } link_t;

    // tunnel entry write
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   index;
        logic [ADDR_W-1:0]  local_addr;
        logic [ADDR_W-1:0]  remote_addr;
        logic [PROTO_W-1:0] proto;
        logic               up;
    } entry_wr_t;

    // lookup key broadcast to all cells
    typedef struct packed {
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [PROTO_W-1:0] proto;
    } key_t;

endpackage

FILE: rtl/gre_tm_cell.sv
// ----------------------------------------------------------------------------
// gre_tm_cell
// One tunnel table slot. Holds the entry and passes the search token on,
// claiming it when the token is still unmatched and this slot matches.
// ----------------------------------------------------------------------------
module gre_tm_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gre_tm_pkg::entry_wr_t wr,
    input  gre_tm_pkg::key_t      key,
    input  gre_tm_pkg::link_t     link_in,
    output gre_tm_pkg::link_t     link_out
);

    localparam bit IN_RANGE = CELL_ID < gre_tm_pkg::SLOTS;
    localparam logic [gre_tm_pkg::IDX_W-1:0] ID = gre_tm_pkg::IDX_W'(CELL_ID);

    logic [gre_tm_pkg::ADDR_W-1:0]  local_reg;
    logic [gre_tm_pkg::ADDR_W-1:0]  remote_reg;
    logic [gre_tm_pkg::PROTO_W-1:0] proto_reg;
    logic                           active_reg;
    gre_tm_pkg::link_t              link_reg;
    gre_tm_pkg::link_t              link_next;
    logic                           wr_hit;
    logic                           match;

    assign wr_hit = IN_RANGE && wr.en && (wr.index == ID);
    assign match  = active_reg && (remote_reg == key.src) && (local_reg == key.dst)
                    && (proto_reg == key.proto);

    always_comb
    begin
        link_next = link_in;
        if (link_in.valid && !link_in.found && match)
        begin
            link_next.found = 1'b1;
            link_next.hit   = ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            link_reg   <= '0;
        end
        else
        begin
            link_reg <= link_next;
            if (wr_hit)
            begin
                active_reg <= wr.up;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            local_reg  <= wr.local_addr;
            remote_reg <= wr.remote_addr;
            proto_reg  <= wr.proto;
        end
    end

    assign link_out = link_reg;

endmodule

FILE: rtl/gre_tunnel_match_and_header_parse.sv
// ----------------------------------------------------------------------------
// gre_tunnel_match_and_header_parse
// GRE tunnel table with lookup and RFC 1701 header length / delivery decode.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A table write goes straight to its
// cell on acceptance; a classify request sends the search token down the
// chain of tunnel cells, one cell per clock. The result is then loaded into
// the output register, and the next request is accepted once it has been
// loaded. A result waits to be loaded while the output is stalled with an
// earlier result still held. The first up tunnel in slot order that matches
// source, destination and protocol wins. A finished result sits in the
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module gre_tunnel_match_and_header_parse #(
    parameter int TUNNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  entry_index,
    input  logic [31:0] entry_local_addr,
    input  logic [31:0] entry_remote_addr,
    input  logic [7:0]  entry_proto,
    input  logic        entry_up,
    input  logic [31:0] ip_src,
    input  logic [31:0] ip_dst,
    input  logic [7:0]  ip_proto,
    input  logic [5:0]  ip_header_len,
    input  logic [15:0] gre_flags,
    input  logic [15:0] gre_ptype,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [3:0]  tunnel_index,
    output logic [6:0]  payload_offset
);

    gre_tm_pkg::state_t    state_reg, state_next;
    logic                  in_accept;
    logic                  out_free;

    logic                  atalk_en_reg;
    logic                  start_reg, start_next;
    gre_tm_pkg::key_t      key_reg, key_next;
    logic [gre_tm_pkg::HLEN_W-1:0] hlen_reg, hlen_next;
    logic [gre_tm_pkg::WORD_W-1:0] flags_reg, flags_next;
    logic [gre_tm_pkg::WORD_W-1:0] ptype_reg, ptype_next;

    logic [gre_tm_pkg::VERD_W-1:0] res_verd_reg, res_verd_next;
    logic [gre_tm_pkg::IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [gre_tm_pkg::OFF_W-1:0]  res_off_reg, res_off_next;

    logic                          out_valid_reg, out_valid_next;
    logic [gre_tm_pkg::VERD_W-1:0] out_verd_reg;
    logic [gre_tm_pkg::IDX_W-1:0]  out_idx_reg;
    logic [gre_tm_pkg::OFF_W-1:0]  out_off_reg;

    gre_tm_pkg::entry_wr_t wr;
    gre_tm_pkg::link_t     link [TUNNELS+1];
    gre_tm_pkg::link_t     tail;

    logic                          take_search;
    logic                          load_out;
    logic                          reject;
    logic [gre_tm_pkg::VERD_W-1:0] kind;
    logic [gre_tm_pkg::OFF_W-1:0]  total;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_accept = in_valid && !in_stall;
    assign tail      = link[TUNNELS];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gre_tm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == gre_tm_pkg::FUNC_CLASSIFY) ?
                                 gre_tm_pkg::ST_SEARCH : gre_tm_pkg::ST_FINISH;
                end
            end
            gre_tm_pkg::ST_SEARCH:
            begin
                if (tail.valid)
                begin
                    state_next = gre_tm_pkg::ST_FINISH;
                end
            end
            gre_tm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = gre_tm_pkg::ST_IDLE;
                end
            end
            default: state_next = gre_tm_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall    = 1'b1;
        take_search = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            gre_tm_pkg::ST_IDLE:   in_stall    = 1'b0;
            gre_tm_pkg::ST_SEARCH: take_search = tail.valid;
            gre_tm_pkg::ST_FINISH: load_out    = out_free;
            default:               in_stall    = 1'b1;
        endcase
    end

    assign wr.en          = in_accept && (func == gre_tm_pkg::FUNC_WRITE);
    assign wr.index       = entry_index;
    assign wr.local_addr  = entry_local_addr;
    assign wr.remote_addr = entry_remote_addr;
    assign wr.proto       = entry_proto;
    assign wr.up          = entry_up;

    assign link[0] = '{valid: start_reg, found: 1'b0, hit: '0};

    genvar gi;
    generate
        for (gi = 0; gi < TUNNELS; gi++)
        begin : g_cell
            gre_tm_cell #(
                .CELL_ID (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (wr),
                .key      (key_reg),
                .link_in  (link[gi]),
                .link_out (link[gi+1])
            );
        end
    endgenerate

    // header decode
    always_comb
    begin
        total = {1'b0, hlen_reg} + gre_tm_pkg::GRE_BASE_LEN;
        if (flags_reg[gre_tm_pkg::BIT_CSUM] || flags_reg[gre_tm_pkg::BIT_ROUTE])
        begin
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        end
        if (flags_reg[gre_tm_pkg::BIT_KEY])
        begin
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        end
        if (flags_reg[gre_tm_pkg::BIT_SEQ])
        begin
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        end

        kind = gre_tm_pkg::VERDICT_RAW;
        if (ptype_reg == gre_tm_pkg::TYPE_IPV4 || ptype_reg == gre_tm_pkg::TYPE_WCCP)
        begin
            kind = gre_tm_pkg::VERDICT_IP;
        end
        else if (ptype_reg == gre_tm_pkg::TYPE_ATALK && atalk_en_reg)
        begin
            kind = gre_tm_pkg::VERDICT_ATALK;
        end

        reject = (key_reg.proto != gre_tm_pkg::PROTO_GRE)
                 || flags_reg[gre_tm_pkg::BIT_ROUTE]
                 || (kind == gre_tm_pkg::VERDICT_RAW);
    end

    // request and result registers
    always_comb
    begin
        start_next    = in_accept && (func == gre_tm_pkg::FUNC_CLASSIFY);
        key_next      = key_reg;
        hlen_next     = hlen_reg;
        flags_next    = flags_reg;
        ptype_next    = ptype_reg;
        res_verd_next = res_verd_reg;
        res_idx_next  = res_idx_reg;
        res_off_next  = res_off_reg;

        if (in_accept)
        begin
            key_next      = '{src: ip_src, dst: ip_dst, proto: ip_proto};
            hlen_next     = ip_header_len;
            flags_next    = gre_flags;
            ptype_next    = gre_ptype;
            res_verd_next = gre_tm_pkg::VERDICT_RAW;
            res_idx_next  = '0;
            res_off_next  = '0;
        end
        else if (take_search && tail.found)
        begin
            res_idx_next = tail.hit;
            if (!reject)
            begin
                res_verd_next = kind;
                res_off_next  = total;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gre_tm_pkg::ST_IDLE;
            atalk_en_reg  <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                atalk_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hlen_reg     <= hlen_next;
        flags_reg    <= flags_next;
        ptype_reg    <= ptype_next;
        res_verd_reg <= res_verd_next;
        res_idx_reg  <= res_idx_next;
        res_off_reg  <= res_off_next;
        if (load_out)
        begin
            out_verd_reg <= res_verd_reg;
            out_idx_reg  <= res_idx_reg;
            out_off_reg  <= res_off_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = out_verd_reg;
    assign tunnel_index   = out_idx_reg;
    assign payload_offset = out_off_reg;

endmodule

FILE: verif/tb_gre_tunnel_match_and_header_parse.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gre_tunnel_match_and_header_parse
// Self-checking bench for the GRE tunnel match and header parse block.
// Tunnel writes and header classify requests go in through the request
// channel. A behavioral copy of the tunnel table predicts verdict, tunnel
// slot and payload offset for each accepted request, and every result is
// checked in order. A directed pass covers field extremes, lookup priority,
// the reject paths and the AppleTalk enable. Random traffic then runs with
// bursty gaps and output stalls, and ends with a stretch without gaps or stalls.
// ----------------------------------------------------------------------------
module tb_gre_tunnel_match_and_header_parse;

    localparam int TUNNEL_COUNT = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic        func;
        logic [3:0]  entry_index;
        logic [31:0] entry_local_addr;
        logic [31:0] entry_remote_addr;
        logic [7:0]  entry_proto;
        logic        entry_up;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [7:0]  ip_proto;
        logic [5:0]  ip_header_len;
        logic [15:0] gre_flags;
        logic [15:0] gre_ptype;
    } gre_req_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] tunnel_index;
        logic [6:0] payload_offset;
    } gre_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [3:0]  entry_index;
    logic [31:0] entry_local_addr;
    logic [31:0] entry_remote_addr;
    logic [7:0]  entry_proto;
    logic        entry_up;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [7:0]  ip_proto;
    logic [5:0]  ip_header_len;
    logic [15:0] gre_flags;
    logic [15:0] gre_ptype;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  verdict;
    logic [3:0]  tunnel_index;
    logic [6:0]  payload_offset;

    // shadow tunnel table and register
    logic [31:0] tun_local_addr  [TUNNEL_COUNT];
    logic [31:0] tun_remote_addr [TUNNEL_COUNT];
    logic [7:0]  tun_proto       [TUNNEL_COUNT];
    logic        tun_up          [TUNNEL_COUNT];
    logic        appletalk_on;

    gre_result_t expected_outcomes[$];
    logic [31:0] addr_pool[8];
    int          fail_count;
    int          cycle_count;
    logic        in_gaps_on;
    logic        out_stalls_on;

    gre_tunnel_match_and_header_parse #(
        .TUNNELS(TUNNEL_COUNT)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .entry_index       (entry_index),
        .entry_local_addr  (entry_local_addr),
        .entry_remote_addr (entry_remote_addr),
        .entry_proto       (entry_proto),
        .entry_up          (entry_up),
        .ip_src            (ip_src),
        .ip_dst            (ip_dst),
        .ip_proto          (ip_proto),
        .ip_header_len     (ip_header_len),
        .gre_flags         (gre_flags),
        .gre_ptype         (gre_ptype),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .verdict           (verdict),
        .tunnel_index      (tunnel_index),
        .payload_offset    (payload_offset)
    );

    always #6 clk = ~clk;

    // Updates the shadow table for writes and returns the expected result.
    function automatic gre_result_t predict_gre_outcome(input gre_req_t r);
        gre_result_t res;
        logic        found;
        logic [3:0]  hit;
        logic [6:0]  total;
        res   = '0;
        found = 1'b0;
        hit   = '0;
        if (r.func == gre_tm_pkg::FUNC_WRITE)
        begin
            if (int'(r.entry_index) < TUNNEL_COUNT)
            begin
                tun_local_addr[r.entry_index]  = r.entry_local_addr;
                tun_remote_addr[r.entry_index] = r.entry_remote_addr;
                tun_proto[r.entry_index]       = r.entry_proto;
                tun_up[r.entry_index]          = r.entry_up;
            end
            return res;
        end
        for (int i = 0; i < TUNNEL_COUNT; i++)
        begin
            if (!found && tun_up[i] && tun_remote_addr[i] == r.ip_src &&
                tun_local_addr[i] == r.ip_dst && tun_proto[i] == r.ip_proto)
            begin
                found = 1'b1;
                hit   = 4'(i);
            end
        end
        if (!found)
            return res;
        res.tunnel_index = hit;
        if (r.ip_proto != gre_tm_pkg::PROTO_GRE || r.gre_flags[gre_tm_pkg::BIT_ROUTE])
            return res;
        total = 7'(r.ip_header_len) + gre_tm_pkg::GRE_BASE_LEN;
        if (r.gre_flags[gre_tm_pkg::BIT_CSUM] || r.gre_flags[gre_tm_pkg::BIT_ROUTE])
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        if (r.gre_flags[gre_tm_pkg::BIT_KEY])
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        if (r.gre_flags[gre_tm_pkg::BIT_SEQ])
            total = total + gre_tm_pkg::GRE_OPT_LEN;
        if (r.gre_ptype == gre_tm_pkg::TYPE_IPV4 || r.gre_ptype == gre_tm_pkg::TYPE_WCCP)
            res.verdict = gre_tm_pkg::VERDICT_IP;
        else if (r.gre_ptype == gre_tm_pkg::TYPE_ATALK && appletalk_on)
            res.verdict = gre_tm_pkg::VERDICT_ATALK;
        else
            res.verdict = gre_tm_pkg::VERDICT_RAW;
        if (res.verdict != gre_tm_pkg::VERDICT_RAW)
            res.payload_offset = total;
        return res;
    endfunction

    function automatic gre_req_t random_req();
        gre_req_t r;
        r.func              = 1'($urandom);
        r.entry_index       = 4'($urandom);
        r.entry_local_addr  = $urandom;
        r.entry_remote_addr = $urandom;
        r.entry_proto       = 8'($urandom);
        r.entry_up          = 1'($urandom);
        r.ip_src            = $urandom;
        r.ip_dst            = $urandom;
        r.ip_proto          = 8'($urandom);
        r.ip_header_len     = 6'($urandom);
        r.gre_flags         = 16'($urandom);
        r.gre_ptype         = 16'($urandom);
        return r;
    endfunction

    function automatic gre_req_t make_write(input logic [3:0] idx, input logic [31:0] loc,
                                            input logic [31:0] rem, input logic [7:0] proto,
                                            input logic up);
        gre_req_t r;
        r                   = random_req();
        r.func              = gre_tm_pkg::FUNC_WRITE;
        r.entry_index       = idx;
        r.entry_local_addr  = loc;
        r.entry_remote_addr = rem;
        r.entry_proto       = proto;
        r.entry_up          = up;
        return r;
    endfunction

    function automatic gre_req_t make_header(input logic [31:0] src, input logic [31:0] dst,
                                             input logic [7:0] proto, input logic [5:0] hlen,
                                             input logic [15:0] flags, input logic [15:0] ptype);
        gre_req_t r;
        r               = random_req();
        r.func          = gre_tm_pkg::FUNC_CLASSIFY;
        r.ip_src        = src;
        r.ip_dst        = dst;
        r.ip_proto      = proto;
        r.ip_header_len = hlen;
        r.gre_flags     = flags;
        r.gre_ptype     = ptype;
        return r;
    endfunction

    task automatic send_request(input gre_req_t r);
        @(negedge clk);
        if (in_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        func              = r.func;
        entry_index       = r.entry_index;
        entry_local_addr  = r.entry_local_addr;
        entry_remote_addr = r.entry_remote_addr;
        entry_proto       = r.entry_proto;
        entry_up          = r.entry_up;
        ip_src            = r.ip_src;
        ip_dst            = r.ip_dst;
        ip_proto          = r.ip_proto;
        ip_header_len     = r.ip_header_len;
        gre_flags         = r.gre_flags;
        gre_ptype         = r.gre_ptype;
        in_valid          = 1'b1;
        do @(posedge clk); while (in_stall);
        expected_outcomes.push_back(predict_gre_outcome(r));
    endtask

    task automatic drain_requests();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_outcomes.size() != 0) @(posedge clk);
        repeat (TUNNEL_COUNT + 4) @(posedge clk);
    endtask

    task automatic write_appletalk(input logic en);
        @(negedge clk);
        cfg_data  = en;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        appletalk_on = en;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // lookup priority, reject paths, header length extremes
    task automatic test_directed_lookup();
        logic [31:0] k_loc;
        logic [31:0] k_rem;
        k_loc = 32'hC0A8_0001;
        k_rem = 32'hC0A8_0002;
        write_appletalk(1'b0);
        send_request(make_header(32'h0, 32'h0, 8'h0, 6'd20, 16'h0, gre_tm_pkg::TYPE_IPV4));
        send_request(make_write(4'd0, 32'hFFFF_FFFF, 32'h0, gre_tm_pkg::PROTO_GRE, 1'b1));
        send_request(make_write(4'd15, 32'h0, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        send_request(make_write(4'd3, 32'h0A00_0001, 32'h0A00_0002, gre_tm_pkg::PROTO_GRE,
                                1'b0));
        send_request(make_write(4'd7, k_loc, k_rem, gre_tm_pkg::PROTO_GRE, 1'b1));
        send_request(make_write(4'd2, k_loc, k_rem, gre_tm_pkg::PROTO_GRE, 1'b1));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd20, 16'h0,
                                 gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd60, 16'hB000,
                                 gre_tm_pkg::TYPE_WCCP));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd20, 16'hFFFF,
                                 gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(32'hFFFF_FFFF, 32'h0, 8'hFF, 6'd20, 16'h0,
                                 gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd24, 16'h0,
                                 gre_tm_pkg::TYPE_ATALK));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd20, 16'h0,
                                 16'hFFFF));
        send_request(make_header(32'h0A00_0002, 32'h0A00_0001, gre_tm_pkg::PROTO_GRE, 6'd20,
                                 16'h0, gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(k_rem, k_loc, gre_tm_pkg::PROTO_GRE, 6'd63, 16'h8FFF,
                                 gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(k_rem, k_loc, gre_tm_pkg::PROTO_GRE, 6'd0, 16'h1000,
                                 gre_tm_pkg::TYPE_WCCP));
        send_request(make_header(k_rem, k_loc, gre_tm_pkg::PROTO_GRE, 6'd40, 16'h2000,
                                 16'h0000));
        send_request(make_write(4'd2, k_loc, k_rem, gre_tm_pkg::PROTO_GRE, 1'b0));
        send_request(make_header(k_rem, k_loc, gre_tm_pkg::PROTO_GRE, 6'd20, 16'h3000,
                                 gre_tm_pkg::TYPE_IPV4));
        send_request(make_header(32'h0, 32'hFFFF_FFFF, 8'd46, 6'd20, 16'h0,
                                 gre_tm_pkg::TYPE_IPV4));
        drain_requests();
    endtask

    task automatic test_appletalk_delivery();
        write_appletalk(1'b1);
        send_request(make_header(32'h0, 32'hFFFF_FFFF, gre_tm_pkg::PROTO_GRE, 6'd20, 16'hA000,
                                 gre_tm_pkg::TYPE_ATALK));
        send_request(make_header(32'hC0A8_0002, 32'hC0A8_0001, gre_tm_pkg::PROTO_GRE, 6'd20,
                                 16'h4000, gre_tm_pkg::TYPE_ATALK));
        send_request(make_header(32'hFFFF_FFFF, 32'h0, 8'hFF, 6'd20, 16'h0,
                                 gre_tm_pkg::TYPE_ATALK));
        send_request(make_header(32'hC0A8_0002, 32'hC0A8_0001, gre_tm_pkg::PROTO_GRE, 6'd60,
                                 16'h7000, 16'h809A));
        drain_requests();
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return addr_pool[$urandom_range(0, 7)];
    endfunction

    // mostly classify requests aimed at table entries, some noise and rewrites
    task automatic test_random_traffic(input int count, input logic atalk);
        gre_req_t r;
        int       slot;
        int       pick;
        int       ptype_pick;
        write_appletalk(atalk);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r = make_write(4'($urandom), pick_addr(), pick_addr(),
                               ($urandom_range(0, 9) < 7) ? gre_tm_pkg::PROTO_GRE :
                                                            8'($urandom),
                               $urandom_range(0, 9) != 0);
            end
            else
            begin
                r    = random_req();
                pick = $urandom_range(0, 19);
                slot = $urandom_range(0, TUNNEL_COUNT - 1);
                if (pick < 14)
                begin
                    r = make_header(tun_remote_addr[slot], tun_local_addr[slot],
                                    tun_proto[slot], r.ip_header_len, r.gre_flags,
                                    r.gre_ptype);
                    if (pick == 0)
                        r.ip_proto = gre_tm_pkg::PROTO_GRE;
                end
                else if (pick < 17)
                begin
                    r = make_header(pick_addr(), pick_addr(), gre_tm_pkg::PROTO_GRE,
                                    r.ip_header_len, r.gre_flags, r.gre_ptype);
                end
                else
                begin
                    r.func = gre_tm_pkg::FUNC_CLASSIFY;
                end
                if ($urandom_range(0, 6) != 0)
                    r.ip_header_len = 6'($urandom_range(20, 60));
                if ($urandom_range(0, 4) != 0)
                    r.gre_flags[gre_tm_pkg::BIT_ROUTE] = 1'b0;
                ptype_pick = $urandom_range(0, 5);
                if (ptype_pick < 2)
                    r.gre_ptype = gre_tm_pkg::TYPE_IPV4;
                else if (ptype_pick == 2)
                    r.gre_ptype = gre_tm_pkg::TYPE_WCCP;
                else if (ptype_pick == 3)
                    r.gre_ptype = gre_tm_pkg::TYPE_ATALK;
            end
            send_request(r);
        end
        drain_requests();
    endtask

    always @(posedge clk)
    begin : check_results
        gre_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result verdict=%0d tunnel=%0d offset=%0d",
                         $time, verdict, tunnel_index, payload_offset);
                fail_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (verdict !== want.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want.verdict, verdict);
                    fail_count++;
                end
                if (tunnel_index !== want.tunnel_index)
                begin
                    $display("%0t: tunnel_index expected %0d actual %0d",
                             $time, want.tunnel_index, tunnel_index);
                    fail_count++;
                end
                if (payload_offset !== want.payload_offset)
                begin
                    $display("%0t: payload_offset expected %0d actual %0d",
                             $time, want.payload_offset, payload_offset);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && out_stalls_on && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 9);
            out_stall = (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_gre_tunnel_match_and_header_parse failed");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = 1'b0;
        in_valid          = 1'b0;
        func              = gre_tm_pkg::FUNC_WRITE;
        entry_index       = '0;
        entry_local_addr  = '0;
        entry_remote_addr = '0;
        entry_proto       = '0;
        entry_up          = 1'b0;
        ip_src            = '0;
        ip_dst            = '0;
        ip_proto          = '0;
        ip_header_len     = '0;
        gre_flags         = '0;
        gre_ptype         = '0;
        fail_count        = 0;
        cycle_count       = 0;
        in_gaps_on        = 1'b0;
        out_stalls_on     = 1'b0;
        appletalk_on      = 1'b0;
        for (int i = 0; i < TUNNEL_COUNT; i++)
        begin
            tun_local_addr[i]  = '0;
            tun_remote_addr[i] = '0;
            tun_proto[i]       = '0;
            tun_up[i]          = 1'b0;
        end
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            addr_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_lookup();
        test_appletalk_delivery();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        test_random_traffic(150, 1'b1);
        test_random_traffic(150, 1'b0);
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        test_random_traffic(100, 1'b1);

        if (fail_count == 0)
            $display("tb_gre_tunnel_match_and_header_parse passed");
        else
            $display("tb_gre_tunnel_match_and_header_parse failed");
        $finish;
    end

endmodule
